### design/touch_level_settling_filter_assert.svh
// assertion macros for the touch level settling filter
`ifndef TOUCH_LEVEL_SETTLING_FILTER_ASSERT_SVH
`define TOUCH_LEVEL_SETTLING_FILTER_ASSERT_SVH
`ifndef SYNTH
`define TLSF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("tlsf assertion failed");
`define TLSF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("tlsf assertion failed");
`else
`define TLSF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define TLSF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

### design/tlsf_pkg.sv
// shared constants, register codes and control types of the touch level settling filter
`default_nettype none
package tlsf_pkg;
	localparam int READING_BITS_DEF = 16;
	localparam int RAW_BITS = 16;
	localparam int PCT_BITS = 10;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int LEVEL_BITS = 17;
	localparam int ACC_BITS = 24;

	localparam logic [PCT_BITS-1:0] NOISE_PERCENT_RST = 10'd30;
	localparam logic [RAW_BITS-1:0] IN_LOW_RST = 16'd0;
	localparam logic [RAW_BITS-1:0] IN_HIGH_RST = 16'hFFFF;
	localparam logic signed [OUT_BITS-1:0] OUT_LOW_RST = 16'sd0;
	localparam logic signed [OUT_BITS-1:0] OUT_HIGH_RST = 16'sd127;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NOISE_PERCENT = 3'd0,
		REG_AUTO_RAISE    = 3'd1,
		REG_IN_LOW        = 3'd2,
		REG_IN_HIGH       = 3'd3,
		REG_OUT_LOW       = 3'd4,
		REG_OUT_HIGH      = 3'd5,
		REG_MAP_ENABLE    = 3'd6
	} tlsf_reg_t;

	typedef struct packed {
		logic load_raw;
		logic update;
		logic prep;
		logic map_mul;
		logic div_start;
		logic load_out;
	} tlsf_cmd_t;

	typedef struct packed {
		logic div_done;
		logic range_empty;
	} tlsf_sts_t;
endpackage
`default_nettype wire

### design/tlsf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module tlsf_div #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quotient,
	output logic          done
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_nx;
	logic          ge;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= rem_nx[DW-1:0];
		end
	end

	assign quotient = quo_q;
	assign done = done_q;
endmodule
`default_nettype wire

### design/tlsf_datapath.sv
// filter state, settling arithmetic, range mapping and result register
`default_nettype none
module tlsf_datapath #(
	parameter int READING_BITS = tlsf_pkg::READING_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tlsf_pkg::tlsf_cmd_t                    cmd,
	output tlsf_pkg::tlsf_sts_t                    sts,
	input  logic [READING_BITS-1:0]                raw,
	input  logic [tlsf_pkg::PCT_BITS-1:0]          noise_percent,
	input  logic                                   auto_raise_high,
	input  logic                                   map_enable,
	input  logic [READING_BITS-1:0]                range_low,
	input  logic [READING_BITS-1:0]                range_high,
	input  logic                                   reload,
	input  logic signed [tlsf_pkg::OUT_BITS-1:0]   out_low,
	input  logic signed [tlsf_pkg::OUT_BITS-1:0]   out_high,
	output logic signed [tlsf_pkg::LEVEL_BITS-1:0] level
);
	import tlsf_pkg::*;

	localparam int RB = READING_BITS;
	localparam int RPW = RB + PCT_BITS;
	localparam int CMPW = (RB + 11 > ACC_BITS + 7) ? RB + 11 : ACC_BITS + 7;
	localparam int SUMW = ((RB + 1 > ACC_BITS) ? RB + 1 : ACC_BITS) + 1;
	localparam int RW = RB + 4;
	localparam int PW = RB + OUT_BITS;
	localparam int QW = PW + 1;
	localparam int LW = QW + 1;
	localparam logic signed [SUMW-1:0] ACC_MAX_X = SUMW'((1 << (ACC_BITS - 1)) - 1);
	localparam logic signed [SUMW-1:0] ACC_MIN_X = ~ACC_MAX_X;

	logic [RB-1:0]                raw_q;
	logic [RPW-1:0]               rp_q;
	logic [RB-1:0]                settled_q;
	logic [RB-1:0]                high_q;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic [RB-1:0]                smag_q;
	logic [RB-1:0]                hmag_q;
	logic [OUT_BITS-1:0]          omag_q;
	logic                         qneg_q;
	logic                         empty_q;
	logic [PW-1:0]                pmag_q;
	logic signed [LEVEL_BITS-1:0] level_q;

	// settling update
	logic signed [RB:0]         diff;
	logic [RB:0]                dmag;
	logic [CMPW-1:0]            dm_x;
	logic [CMPW-1:0]            rp_x;
	logic [CMPW-1:0]            dead_cmp;
	logic                       dead;
	logic signed [ACC_BITS-1:0] acc_rnd;
	logic signed [ACC_BITS-1:0] acc_half;
	logic signed [SUMW-1:0]     acc_sum;
	logic signed [ACC_BITS-1:0] acc_sat;
	logic signed [ACC_BITS-1:0] acc_new;
	logic [ACC_BITS-1:0]        amag;
	logic [CMPW-1:0]            am_x;
	logic [CMPW-1:0]            thr_cmp;
	logic                       settle;
	logic [RW-1:0]              r10;
	logic [RW-1:0]              h11;
	logic                       raise;

	assign diff = $signed({1'b0, raw_q}) - $signed({1'b0, settled_q});
	assign dmag = diff[RB] ? (RB+1)'(-diff) : (RB+1)'(diff);
	assign dm_x = CMPW'(dmag);
	assign rp_x = CMPW'(rp_q);
	// 2000 * |diff| against raw * percent
	assign dead_cmp = (dm_x << 11) - (dm_x << 5) - (dm_x << 4);
	assign dead = (dmag <= (RB+1)'(2)) || (dead_cmp <= rp_x);

	assign acc_rnd = acc_q + $signed(ACC_BITS'(acc_q[ACC_BITS-1]));
	assign acc_half = acc_rnd >>> 1;
	assign acc_sum = SUMW'(acc_q) + SUMW'(diff);
	always_comb begin
		if (acc_sum > ACC_MAX_X) begin
			acc_sat = ACC_BITS'(ACC_MAX_X);
		end else if (acc_sum < ACC_MIN_X) begin
			acc_sat = ACC_BITS'(ACC_MIN_X);
		end else begin
			acc_sat = ACC_BITS'(acc_sum);
		end
	end
	assign acc_new = dead ? acc_half : acc_sat;
	assign amag = acc_new[ACC_BITS-1] ? ACC_BITS'(-acc_new) : ACC_BITS'(acc_new);
	assign am_x = CMPW'(amag);
	// 100 * |acc| against raw * percent
	assign thr_cmp = (am_x << 6) + (am_x << 5) + (am_x << 2);
	assign settle = rp_x < thr_cmp;

	assign r10 = (RW'(raw_q) << 3) + (RW'(raw_q) << 1);
	assign h11 = (RW'(high_q) << 3) + (RW'(high_q) << 1) + RW'(high_q);
	assign raise = auto_raise_high && (r10 > h11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settled_q <= RB'(IN_LOW_RST);
			high_q <= RB'(IN_HIGH_RST);
			acc_q <= '0;
		end else if (reload) begin
			settled_q <= range_low;
			high_q <= range_high;
			acc_q <= '0;
		end else if (cmd.update) begin
			if (raise) begin
				high_q <= raw_q;
			end
			if (settle) begin
				settled_q <= raw_q;
				acc_q <= '0;
			end else begin
				acc_q <= acc_new;
			end
		end
	end

	// range mapping operands
	logic signed [RB:0]         sdiff;
	logic signed [RB:0]         hdiff;
	logic signed [OUT_BITS:0]   odiff;
	logic [PW-1:0]              quo;
	logic                       div_done;
	logic signed [QW-1:0]       qs;
	logic signed [LW-1:0]       lsum;
	logic signed [OUT_BITS-1:0] lb;
	logic signed [OUT_BITS-1:0] ub;
	logic signed [OUT_BITS-1:0] clamped;
	logic signed [OUT_BITS-1:0] mapped;
	logic signed [LEVEL_BITS-1:0] level_n;

	assign sdiff = $signed({1'b0, settled_q}) - $signed({1'b0, range_low});
	assign hdiff = $signed({1'b0, high_q}) - $signed({1'b0, range_low});
	assign odiff = (OUT_BITS+1)'(out_high) - (OUT_BITS+1)'(out_low);

	always_ff @(posedge clk) begin
		if (cmd.load_raw) begin
			raw_q <= raw;
			rp_q <= RPW'(raw) * RPW'(noise_percent);
		end
		if (cmd.prep) begin
			smag_q <= sdiff[RB] ? RB'(-sdiff) : RB'(sdiff);
			hmag_q <= hdiff[RB] ? RB'(-hdiff) : RB'(hdiff);
			omag_q <= odiff[OUT_BITS] ? OUT_BITS'(-odiff) : OUT_BITS'(odiff);
			qneg_q <= sdiff[RB] ^ hdiff[RB] ^ odiff[OUT_BITS];
			empty_q <= (hdiff == '0);
		end
		if (cmd.map_mul) begin
			pmag_q <= PW'(smag_q) * PW'(omag_q);
		end
		if (cmd.load_out) begin
			level_q <= level_n;
		end
	end

	tlsf_div #(
		.NW(PW),
		.DW(RB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (pmag_q),
		.divisor  (hmag_q),
		.quotient (quo),
		.done     (div_done)
	);

	assign qs = qneg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign lsum = LW'(qs) + LW'(out_low);
	assign lb = (out_low < out_high) ? out_low : out_high;
	assign ub = (out_low < out_high) ? out_high : out_low;

	always_comb begin
		if (lsum < LW'(lb)) begin
			clamped = lb;
		end else if (lsum > LW'(ub)) begin
			clamped = ub;
		end else begin
			clamped = OUT_BITS'(lsum);
		end
	end

	assign mapped = empty_q ? out_low : clamped;
	assign level_n = map_enable ? LEVEL_BITS'(mapped) : $signed(LEVEL_BITS'(settled_q));

	assign sts = {div_done, empty_q};
	assign level = level_q;
endmodule
`default_nettype wire

### design/tlsf_ctrl.sv
// sequencing state machine and result handshake of the touch level settling filter
`default_nettype none
`include "touch_level_settling_filter_assert.svh"
module tlsf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                map_enable,
	output tlsf_pkg::tlsf_cmd_t cmd,
	input  tlsf_pkg::tlsf_sts_t sts
);
	import tlsf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_PREP,
		S_MUL,
		S_DSTART,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_slot;

	assign out_slot = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load_raw = in_valid && (state_q == S_IDLE);
		cmd.update = (state_q == S_UPD);
		cmd.prep = (state_q == S_PREP);
		cmd.map_mul = (state_q == S_MUL);
		cmd.div_start = (state_q == S_DSTART);
		cmd.load_out = (state_q == S_FIN) && out_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= map_enable ? S_PREP : S_FIN;
				end
				S_PREP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= sts.range_empty ? S_FIN : S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_slot) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`TLSF_ASSERT_NXT(a_busy_after_accept, clk, arst_n, cmd.load_raw, !in_ready)
	`TLSF_ASSERT_IMP(a_done_only_in_div, clk, arst_n, sts.div_done, state_q == S_DIV)
	`TLSF_ASSERT_IMP(a_no_div_on_empty, clk, arst_n, cmd.div_start, !sts.range_empty)
endmodule
`default_nettype wire

### design/touch_level_settling_filter.sv
// top level: configuration registers, input sizing, controller and datapath
`default_nettype none
// Touch level settling filter. Each raw reading beat yields one level beat. With mapping
// off an item passes the update and finish states only. With mapping on it also passes
// the prepare and multiply states and, unless the input range is empty, the bit-serial
// divider that produces one quotient bit of the READING_BITS + 16 bit range-mapping
// quotient per cycle. A reading is taken only in the idle state. A finished level waits
// in the output register while the next reading is taken. Configuration writes are always
// ready and must be issued only while the block is idle; writing in_low or in_high reloads
// the settled value, the high bound and the accumulator in the cycle after the write.
module touch_level_settling_filter #(
	parameter int READING_BITS = tlsf_pkg::READING_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [tlsf_pkg::RAW_BITS-1:0]          raw_reading,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [tlsf_pkg::LEVEL_BITS-1:0] level,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tlsf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [tlsf_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import tlsf_pkg::*;

	logic [PCT_BITS-1:0]        noise_percent_q;
	logic                       auto_raise_q;
	logic [RAW_BITS-1:0]        in_low_q;
	logic [RAW_BITS-1:0]        in_high_q;
	logic signed [OUT_BITS-1:0] out_low_q;
	logic signed [OUT_BITS-1:0] out_high_q;
	logic                       map_enable_q;
	logic                       reload_q;
	logic                       cfg_write;

	tlsf_cmd_t cmd;
	tlsf_sts_t sts;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_percent_q <= NOISE_PERCENT_RST;
			auto_raise_q <= 1'b0;
			in_low_q <= IN_LOW_RST;
			in_high_q <= IN_HIGH_RST;
			out_low_q <= OUT_LOW_RST;
			out_high_q <= OUT_HIGH_RST;
			map_enable_q <= 1'b0;
			reload_q <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					REG_NOISE_PERCENT: noise_percent_q <= cfg_data[PCT_BITS-1:0];
					REG_AUTO_RAISE: auto_raise_q <= cfg_data[0];
					REG_IN_LOW: begin
						in_low_q <= cfg_data[RAW_BITS-1:0];
						reload_q <= 1'b1;
					end
					REG_IN_HIGH: begin
						in_high_q <= cfg_data[RAW_BITS-1:0];
						reload_q <= 1'b1;
					end
					REG_OUT_LOW: out_low_q <= $signed(cfg_data[OUT_BITS-1:0]);
					REG_OUT_HIGH: out_high_q <= $signed(cfg_data[OUT_BITS-1:0]);
					REG_MAP_ENABLE: map_enable_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	tlsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.map_enable (map_enable_q),
		.cmd        (cmd),
		.sts        (sts)
	);

	tlsf_datapath #(
		.READING_BITS(READING_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.raw             (READING_BITS'(raw_reading)),
		.noise_percent   (noise_percent_q),
		.auto_raise_high (auto_raise_q),
		.map_enable      (map_enable_q),
		.range_low       (READING_BITS'(in_low_q)),
		.range_high      (READING_BITS'(in_high_q)),
		.reload          (reload_q),
		.out_low         (out_low_q),
		.out_high        (out_high_q),
		.level           (level)
	);
endmodule
`default_nettype wire

### test/tb_touch_level_settling_filter.sv
// testbench for the touch level settling filter: directed table, then random readings
`timescale 1ns / 1ps
module tb_touch_level_settling_filter;
	import tlsf_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNKNOWN = 3'd7;
	localparam longint ACC_MAX = 64'sd8388607;
	localparam longint ACC_MIN = -64'sd8388608;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 78;
	localparam int DIR_ROWS = 40;

	typedef enum logic {ROW_READ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_IDX_BITS-1:0]   idx;
		logic [CFG_DATA_BITS-1:0]  val;
		logic                      typed;
		logic [LEVEL_BITS-1:0]     lvl;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_READ, '0, 16'd0, 1'b1, 17'h00000},
		'{ROW_READ, '0, 16'hFFFF, 1'b1, 17'h0FFFF},
		'{ROW_READ, '0, 16'hFFFE, 1'b1, 17'h0FFFF},
		'{ROW_CFG, REG_UNKNOWN, 16'hFFFF, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'hFFFF, 1'b1, 17'h0FFFF},
		'{ROW_CFG, REG_NOISE_PERCENT, 16'hFFFF, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd1, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd0, 1'b0, 17'h0},
		'{ROW_CFG, REG_NOISE_PERCENT, 16'd0, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd3, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd4, 1'b0, 17'h0},
		'{ROW_CFG, REG_OUT_LOW, 16'h8000, 1'b0, 17'h0},
		'{ROW_CFG, REG_OUT_HIGH, 16'h7FFF, 1'b0, 17'h0},
		'{ROW_CFG, REG_MAP_ENABLE, 16'd1, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'hFFFF, 1'b1, 17'h07FFF},
		'{ROW_READ, '0, 16'd0, 1'b1, 17'h18000},
		'{ROW_CFG, REG_OUT_LOW, 16'h7FFF, 1'b0, 17'h0},
		'{ROW_CFG, REG_OUT_HIGH, 16'h8000, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'hFFFF, 1'b1, 17'h18000},
		'{ROW_READ, '0, 16'd0, 1'b1, 17'h07FFF},
		'{ROW_CFG, REG_IN_LOW, 16'd100, 1'b0, 17'h0},
		'{ROW_CFG, REG_IN_HIGH, 16'd100, 1'b0, 17'h0},
		'{ROW_CFG, REG_OUT_LOW, 16'hFFFB, 1'b0, 17'h0},
		'{ROW_CFG, REG_OUT_HIGH, 16'd50, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd100, 1'b1, 17'h1FFFB},
		'{ROW_READ, '0, 16'd5000, 1'b1, 17'h1FFFB},
		'{ROW_CFG, REG_AUTO_RAISE, 16'd1, 1'b0, 17'h0},
		'{ROW_CFG, REG_NOISE_PERCENT, 16'd30, 1'b0, 17'h0},
		'{ROW_CFG, REG_IN_LOW, 16'd0, 1'b0, 17'h0},
		'{ROW_CFG, REG_IN_HIGH, 16'd1000, 1'b0, 17'h0},
		'{ROW_CFG, REG_OUT_LOW, 16'd0, 1'b0, 17'h0},
		'{ROW_CFG, REG_OUT_HIGH, 16'd127, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd2000, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd1000, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd50, 1'b0, 17'h0},
		'{ROW_CFG, REG_IN_LOW, 16'd500, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'd10, 1'b1, 17'h00000},
		'{ROW_CFG, REG_MAP_ENABLE, 16'd0, 1'b0, 17'h0},
		'{ROW_CFG, REG_AUTO_RAISE, 16'd0, 1'b0, 17'h0},
		'{ROW_READ, '0, 16'hAAAA, 1'b0, 17'h0}
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [RAW_BITS-1:0]             raw_reading;
	logic                            out_valid;
	logic                            out_ready;
	logic signed [LEVEL_BITS-1:0]    level;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [CFG_IDX_BITS-1:0]         cfg_index;
	logic [CFG_DATA_BITS-1:0]        cfg_data;

	// shadow registers and filter state
	logic [PCT_BITS-1:0]             pct_r;
	logic                            auto_r;
	logic [RAW_BITS-1:0]             in_low_r;
	logic [RAW_BITS-1:0]             in_high_r;
	logic signed [OUT_BITS-1:0]      out_low_r;
	logic signed [OUT_BITS-1:0]      out_high_r;
	logic                            map_r;
	logic [RAW_BITS-1:0]             settled_r;
	logic [RAW_BITS-1:0]             high_bound_r;
	logic signed [ACC_BITS-1:0]      acc_r;

	logic [LEVEL_BITS-1:0]           expected_levels[$];
	logic [LEVEL_BITS-1:0]           want_level;
	int                              mismatches = 0;
	int                              cycle_count = 0;
	logic                            cfg_open = 1'b0;
	logic                            hold_off_req = 1'b0;
	logic                            stall_mode = 1'b0;
	logic [7:0]                      ready_pat;
	logic [4:0]                      pat_age;

	touch_level_settling_filter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_reading (raw_reading),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level       (level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void reload_range();
		settled_r = in_low_r;
		high_bound_r = in_high_r;
		acc_r = '0;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			REG_NOISE_PERCENT: pct_r = val[PCT_BITS-1:0];
			REG_AUTO_RAISE:    auto_r = val[0];
			REG_IN_LOW: begin
				in_low_r = val;
				reload_range();
			end
			REG_IN_HIGH: begin
				in_high_r = val;
				reload_range();
			end
			REG_OUT_LOW:       out_low_r = val;
			REG_OUT_HIGH:      out_high_r = val;
			REG_MAP_ENABLE:    map_r = val[0];
			default: ;
		endcase
	endfunction

	function automatic logic [LEVEL_BITS-1:0] predict_level(input logic [RAW_BITS-1:0] raw);
		longint thr, dband, diff, mag, acc, lo, hi, lb, ub, lvl;
		thr = (longint'(raw) * longint'(pct_r)) / 100;
		dband = thr / 20;
		if (dband < 2)
			dband = 2;
		if (auto_r && 10 * longint'(raw) > 11 * longint'(high_bound_r))
			high_bound_r = raw;
		diff = longint'(raw) - longint'(settled_r);
		mag = (diff < 0) ? -diff : diff;
		acc = longint'(acc_r);
		if (mag <= dband) begin
			acc = acc / 2;
		end else begin
			acc = acc + diff;
			if (acc > ACC_MAX)
				acc = ACC_MAX;
			if (acc < ACC_MIN)
				acc = ACC_MIN;
		end
		mag = (acc < 0) ? -acc : acc;
		if (mag > thr) begin
			settled_r = raw;
			acc = 0;
		end
		acc_r = acc[ACC_BITS-1:0];
		if (map_r) begin
			lo = longint'(in_low_r);
			hi = longint'(high_bound_r);
			lb = (out_low_r < out_high_r) ? longint'(out_low_r) : longint'(out_high_r);
			ub = (out_low_r < out_high_r) ? longint'(out_high_r) : longint'(out_low_r);
			if (hi == lo)
				lvl = longint'(out_low_r);
			else
				lvl = (longint'(settled_r) - lo) * (longint'(out_high_r) - longint'(out_low_r))
					/ (hi - lo) + longint'(out_low_r);
			if (lvl < lb)
				lvl = lb;
			if (lvl > ub)
				lvl = ub;
		end else begin
			lvl = longint'(settled_r);
		end
		return lvl[LEVEL_BITS-1:0];
	endfunction

	task automatic offer_reading(input logic [RAW_BITS-1:0] raw, input logic typed,
			input logic [LEVEL_BITS-1:0] typed_level);
		logic [LEVEL_BITS-1:0] lvl;
		@(negedge clk);
		in_valid <= 1'b1;
		raw_reading <= raw;
		do @(posedge clk); while (!in_ready);
		lvl = predict_level(raw);
		expected_levels.push_back(typed ? typed_level : lvl);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		pause_sender(1);
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, val);
		cfg_open = 1'b1;
	endtask

	// range reload lands in the cycle after the write
	task automatic cfg_close();
		@(negedge clk);
		cfg_valid <= 1'b0;
		repeat (2) @(negedge clk);
		cfg_open = 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				$error("level: no beat expected, got %h", level);
				mismatches++;
			end else begin
				want_level = expected_levels.pop_front();
				if (level !== want_level) begin
					$error("level: expected %h, got %h", want_level, level);
					mismatches++;
				end
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		ready_pat = 8'hB5;
		pat_age = '0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!stall_mode) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ready_pat[0];
				ready_pat = {ready_pat[0], ready_pat[7:1]};
				pat_age++;
				if (pat_age == 0)
					ready_pat = 8'($urandom) | 8'h01;
			end
		end
	end

	initial begin
		int ph, i, base, spread, nz, tmp, rlo, rhi, sel, burst_left;
		logic [CFG_DATA_BITS-1:0] w_pct, w_auto, w_lo, w_hi, w_ol, w_oh, w_map;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_reading = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_NOISE_PERCENT;
		cfg_data = '0;
		pct_r = NOISE_PERCENT_RST;
		auto_r = 1'b0;
		in_low_r = IN_LOW_RST;
		in_high_r = IN_HIGH_RST;
		out_low_r = OUT_LOW_RST;
		out_high_r = OUT_HIGH_RST;
		map_r = 1'b0;
		reload_range();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG) begin
				if (!cfg_open)
					drain();
				cfg_write(DIR_TAB[i].idx, DIR_TAB[i].val);
			end else begin
				if (cfg_open)
					cfg_close();
				offer_reading(DIR_TAB[i].val, DIR_TAB[i].typed, DIR_TAB[i].lvl);
			end
		end
		offer_reading(16'h5555, 1'b0, '0);

		burst_left = 0;
		base = 0;
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					w_pct = 16'd0;    w_auto = 16'd0;    w_lo = 16'd0;  w_hi = 16'hFFFF;
					w_ol = 16'h8000;  w_oh = 16'h7FFF;   w_map = 16'd1;
				end
				1: begin
					w_pct = 16'hFFFF; w_auto = 16'hFFFF; w_lo = 16'hFFFF; w_hi = 16'd0;
					w_ol = 16'h7FFF;  w_oh = 16'h8000;   w_map = 16'hFFFF;
				end
				default: begin
					case ($urandom_range(0, 4))
						0: w_pct = 16'd0;
						1: w_pct = 16'hFFFF;
						2: w_pct = 16'd1000;
						3: w_pct = 16'($urandom_range(1, 60));
						default: w_pct = 16'($urandom);
					endcase
					w_auto = 16'($urandom);
					w_lo = 16'($urandom_range(0, 50000));
					case ($urandom_range(0, 7))
						0: w_hi = w_lo;
						1: w_hi = 16'($urandom_range(0, w_lo));
						default: w_hi = 16'(w_lo + $urandom_range(1, 65535 - w_lo));
					endcase
					w_ol = 16'($urandom);
					w_oh = 16'($urandom);
					w_map = ($urandom_range(0, 2) != 0) ? 16'($urandom) | 16'h1 : 16'($urandom) & 16'hFFFE;
				end
			endcase
			cfg_write(REG_NOISE_PERCENT, w_pct);
			cfg_write(REG_AUTO_RAISE, w_auto);
			cfg_write(REG_IN_LOW, w_lo);
			cfg_write(REG_IN_HIGH, w_hi);
			cfg_write(REG_OUT_LOW, w_ol);
			cfg_write(REG_OUT_HIGH, w_oh);
			cfg_write(REG_MAP_ENABLE, w_map);
			if (ph % 5 == 3)
				cfg_write(REG_UNKNOWN, 16'($urandom));
			cfg_close();
			stall_mode = (ph % 3 != 0);
			rlo = (in_low_r < in_high_r) ? in_low_r : in_high_r;
			rhi = (in_low_r < in_high_r) ? in_high_r : in_low_r;
			base = $urandom_range(rlo, rhi);

			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 5 && i == 10) begin
					hold_off_req = 1'b1;
					burst_left = 20;
				end else if (burst_left == 0) begin
					if (ph % 4 != 2)
						pause_sender(($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
							: $urandom_range(1, 8));
					burst_left = $urandom_range(1, 16);
				end
				burst_left--;

				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					tmp = $urandom_range(0, 65535);
				end else if (sel == 1) begin
					base = $urandom_range(rlo, rhi + (rhi - rlo) / 4);
					if (base > 65535)
						base = 65535;
					tmp = base;
				end else begin
					// mostly small wobble around the base level
					spread = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
						: $urandom_range(0, base * int'(pct_r) / 1000 + 4);
					nz = int'($urandom_range(0, 2 * spread)) - spread;
					tmp = base + nz;
				end
				if (tmp < 0)
					tmp = 0;
				if (tmp > 65535)
					tmp = 65535;
				offer_reading(16'(tmp), 1'b0, '0);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
